FILE: sv/coverage_weighted_halving_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef COVERAGE_WEIGHTED_HALVING_MACROS_SVH
`define COVERAGE_WEIGHTED_HALVING_MACROS_SVH

// same-cycle implication
`define CWH_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define CWH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/cwh_pkg.sv
// ----------------------------------------------------------------------------
// cwh_pkg
// Types and constants shared by the halving controller and datapath.
// ----------------------------------------------------------------------------
package cwh_pkg;

	localparam int TEXEL_W = 32;
	localparam int CHAN_W  = 8;
	localparam int NCHAN   = 4;
	localparam int DIM_W   = 13;
	localparam int SUM_W   = 18;
	localparam int ASUM_W  = 10;
	localparam int NUM_W   = 19;
	localparam int DEN_W   = 11;
	localparam int REM_W   = 12;
	localparam int QUO_W   = 9;
	localparam int STEP_W  = 4;

	localparam logic [0:0] CFG_WIDTH  = 1'b0;
	localparam logic [0:0] CFG_HEIGHT = 1'b1;

	localparam logic [1:0] CH_ALPHA = 2'd3;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

	typedef struct packed {
		logic       accept;
		logic       fetch;
		logic       mul;
		logic       div;
		logic       store;
		logic       load;
		logic [1:0] ch;
	} cmd_t;

	typedef struct packed {
		logic need_out;
		logic out_busy;
	} sts_t;

endpackage

FILE: sv/cwh_ctrl.sv
// ----------------------------------------------------------------------------
// cwh_ctrl
// Sequencer: accept, quad fetch, per-channel multiply, divide and store, output load.
// ----------------------------------------------------------------------------
module cwh_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  cwh_pkg::sts_t sts,
	output cwh_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {IDLE, FETCH, MUL, DIV, STORE, LOAD} state_t;

	state_t                      state_q;
	logic [1:0]                  ch_q;
	logic [cwh_pkg::STEP_W-1:0]  step_q;
	logic                        accept;

	assign s_tready = (state_q == IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd        = '0;
		cmd.accept = accept;
		cmd.fetch  = (state_q == FETCH);
		cmd.mul    = (state_q == MUL);
		cmd.div    = (state_q == DIV);
		cmd.store  = (state_q == STORE);
		cmd.load   = (state_q == LOAD) && !sts.out_busy;
		cmd.ch     = ch_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ch_q    <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (accept && sts.need_out) begin
						state_q <= FETCH;
						ch_q    <= '0;
					end
				end
				FETCH: state_q <= MUL;
				MUL: begin
					state_q <= DIV;
					step_q  <= '0;
				end
				DIV: begin
					if (step_q == cwh_pkg::LAST_STEP) begin
						state_q <= STORE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				STORE: begin
					if (ch_q == cwh_pkg::CH_ALPHA) begin
						state_q <= LOAD;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= MUL;
					end
				end
				LOAD: begin
					if (!sts.out_busy) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

FILE: sv/cwh_dp.sv
// ----------------------------------------------------------------------------
// cwh_dp
// Position counters, row store, quad gather, weighted sums, restoring divider
// and output register.
// ----------------------------------------------------------------------------
module cwh_dp #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [0:0]                    cfg_index,
	input  logic [cwh_pkg::DIM_W-1:0]     cfg_data,
	input  logic [cwh_pkg::TEXEL_W-1:0]   s_tdata,
	input  cwh_pkg::cmd_t                 cmd,
	output cwh_pkg::sts_t                 sts,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cwh_pkg::TEXEL_W-1:0]   m_tdata,
	output logic                          m_tlast,
	output logic                          m_tuser
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int EWW = (WW > cwh_pkg::DIM_W) ? WW : cwh_pkg::DIM_W;
	localparam int EHW = (HW > cwh_pkg::DIM_W) ? HW : cwh_pkg::DIM_W;
	localparam int TW  = cwh_pkg::TEXEL_W;
	localparam int CHW = cwh_pkg::CHAN_W;

	logic [cwh_pkg::DIM_W-1:0] src_w_q, src_h_q;
	logic [CW-1:0]             col_q;
	logic [RW-1:0]             row_q;
	logic [EWW-1:0]            w_ext;
	logic [EHW-1:0]            h_ext;
	logic [WW-1:0]             w_eff, ow, ox;
	logic [HW-1:0]             h_eff, oh, oy;
	logic                      wone, hone, xdone, ydone, lr, lo, col_end, row_end;

	logic [TW-1:0] mem [MAX_WIDTH];
	logic [TW-1:0] rd_q, ul_q, left_q;
	logic [TW-1:0] q0_q, q1_q, q2_q, q3_q;
	logic          even_s1;
	logic          lr_q, lo_q;

	logic [CHW-1:0]                 a0, a1, a2, a3, c0, c1, c2, c3;
	logic [cwh_pkg::ASUM_W-1:0]     asum, psum;
	logic [cwh_pkg::SUM_W-1:0]      wsum;
	logic [cwh_pkg::NUM_W-1:0]      num;
	logic [cwh_pkg::DEN_W-1:0]      den;
	logic [cwh_pkg::DEN_W-1:0]      den_q;
	logic [cwh_pkg::REM_W-1:0]      rem_q, trial;
	logic [cwh_pkg::QUO_W-1:0]      nbits_q, quo_q;
	logic [CHW-1:0]                 res_q [cwh_pkg::NCHAN];
	logic                           qbit;

	// effective dimensions
	always_comb begin
		w_ext = EWW'(src_w_q);
		h_ext = EHW'(src_h_q);
		if (w_ext == '0) w_eff = WW'(1);
		else if (w_ext > EWW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(w_ext);
		if (h_ext == '0) h_eff = HW'(1);
		else if (h_ext > EHW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
		else h_eff = HW'(h_ext);
		wone    = (w_eff == WW'(1));
		hone    = (h_eff == HW'(1));
		ow      = wone ? WW'(1) : (w_eff >> 1);
		oh      = hone ? HW'(1) : (h_eff >> 1);
		ox      = wone ? '0 : (WW'(col_q) >> 1);
		oy      = hone ? '0 : (HW'(row_q) >> 1);
		xdone   = wone || col_q[0];
		ydone   = hone || row_q[0];
		lr      = (ox == ow - WW'(1));
		lo      = lr && (oy == oh - HW'(1));
		col_end = (WW'(col_q) == w_eff - WW'(1));
		row_end = (HW'(row_q) == h_eff - HW'(1));
	end

	assign sts.need_out = xdone && ydone;
	assign sts.out_busy = m_tvalid && !m_tready;

	// configuration and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= cwh_pkg::DIM_W'(1);
			src_h_q <= cwh_pkg::DIM_W'(1);
			col_q   <= '0;
			row_q   <= '0;
			left_q  <= '0;
			even_s1 <= 1'b0;
		end else begin
			even_s1 <= cmd.accept && !col_q[0];
			if (cfg_valid) begin
				if (cfg_index == cwh_pkg::CFG_WIDTH) src_w_q <= cfg_data;
				else src_h_q <= cfg_data;
				col_q <= '0;
				row_q <= '0;
			end else if (cmd.accept) begin
				if (!wone && !col_q[0]) left_q <= s_tdata;
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// row store
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (!hone && !row_q[0]) mem[col_q] <= s_tdata;
			rd_q <= mem[col_q];
		end
	end

	// quad gather
	always_ff @(posedge clk) begin
		if (even_s1) ul_q <= rd_q;
		if (cmd.accept) begin
			q3_q <= s_tdata;
			q2_q <= wone ? s_tdata : left_q;
			lr_q <= lr;
			lo_q <= lo;
		end
		if (cmd.fetch) begin
			q1_q <= hone ? q3_q : rd_q;
			q0_q <= hone ? q2_q : (wone ? rd_q : ul_q);
		end
	end

	// per-channel sums
	always_comb begin
		a0   = q0_q[TW-1 -: CHW];
		a1   = q1_q[TW-1 -: CHW];
		a2   = q2_q[TW-1 -: CHW];
		a3   = q3_q[TW-1 -: CHW];
		c0   = q0_q[CHW*cmd.ch +: CHW];
		c1   = q1_q[CHW*cmd.ch +: CHW];
		c2   = q2_q[CHW*cmd.ch +: CHW];
		c3   = q3_q[CHW*cmd.ch +: CHW];
		asum = cwh_pkg::ASUM_W'(a0) + cwh_pkg::ASUM_W'(a1)
			+ cwh_pkg::ASUM_W'(a2) + cwh_pkg::ASUM_W'(a3);
		psum = cwh_pkg::ASUM_W'(c0) + cwh_pkg::ASUM_W'(c1)
			+ cwh_pkg::ASUM_W'(c2) + cwh_pkg::ASUM_W'(c3);
		wsum = cwh_pkg::SUM_W'(a0) * cwh_pkg::SUM_W'(c0)
			+ cwh_pkg::SUM_W'(a1) * cwh_pkg::SUM_W'(c1)
			+ cwh_pkg::SUM_W'(a2) * cwh_pkg::SUM_W'(c2)
			+ cwh_pkg::SUM_W'(a3) * cwh_pkg::SUM_W'(c3);
		if (cmd.ch != cwh_pkg::CH_ALPHA && asum != '0) begin
			num = {wsum, 1'b0} + cwh_pkg::NUM_W'(asum);
			den = {asum, 1'b0};
		end else begin
			num = cwh_pkg::NUM_W'({psum, 1'b0}) + cwh_pkg::NUM_W'(4);
			den = cwh_pkg::DEN_W'(8);
		end
		trial = {rem_q[cwh_pkg::REM_W-2:0], nbits_q[cwh_pkg::QUO_W-1]};
		qbit  = (trial >= cwh_pkg::REM_W'(den_q));
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			rem_q   <= cwh_pkg::REM_W'(num >> cwh_pkg::QUO_W);
			nbits_q <= num[cwh_pkg::QUO_W-1:0];
			den_q   <= den;
			quo_q   <= '0;
		end else if (cmd.div) begin
			rem_q   <= qbit ? trial - cwh_pkg::REM_W'(den_q) : trial;
			nbits_q <= nbits_q << 1;
			quo_q   <= {quo_q[cwh_pkg::QUO_W-2:0], qbit};
		end
		if (cmd.store) begin
			res_q[cmd.ch] <= quo_q[cwh_pkg::QUO_W-1] ? '1 : quo_q[CHW-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_tdata <= {res_q[3], res_q[2], res_q[1], res_q[0]};
			m_tlast <= lo_q;
			m_tuser <= lr_q;
		end
	end

endmodule

FILE: sv/coverage_weighted_halving.sv
// ----------------------------------------------------------------------------
// coverage_weighted_halving
// Alpha-weighted 2x2 box downsampler for one RGBA8 level.
// ----------------------------------------------------------------------------
// Source texels enter in raster order over src_width x src_height; one output
// texel is given per 2x2 quad, colour channels weighted by alpha (plain mean
// when the quad alpha sum is zero), alpha as the plain mean, all rounded half
// up. A texel that completes no quad leaves the input ready for the next. A
// texel that completes a quad holds the input off after it is taken: one fetch
// from the row store, then for each of the four channels a multiply-accumulate
// step, the quotient bit steps of the shared restoring divider and a store step,
// then the output load, which waits while the previous result is still
// unaccepted. The output register lets the next texels enter while a result
// waits. Writing either size register restarts the level.
`include "coverage_weighted_halving_macros.svh"

module coverage_weighted_halving #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [cwh_pkg::TEXEL_W-1:0] s_tdata,   // texel
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [cwh_pkg::TEXEL_W-1:0] m_tdata,   // halved_texel
	output logic                        m_tlast,   // last_of_image
	output logic                        m_tuser,   // last_in_row
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [0:0]                  cfg_index,
	input  logic [cwh_pkg::DIM_W-1:0]   cfg_data
);

	cwh_pkg::cmd_t cmd;
	cwh_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	cwh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cwh_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	`CWH_ASSERT_NEXT(a_busy_after_quad, s_tvalid && s_tready && sts.need_out, !s_tready)
	`CWH_ASSERT_NOW(a_last_image_ends_row, m_tvalid && m_tlast, m_tuser)
	`CWH_ASSERT_NOW(a_load_only_when_free, cmd.load, !(m_tvalid && !m_tready))

endmodule

FILE: sim/cwh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwh_checker
// Watches the size, texel and result channels of the downsampler, keeps its
// own copy of the level state, predicts each halved texel with its row flags
// and compares every accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module cwh_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [cwh_pkg::TEXEL_W-1:0] s_tdata,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [cwh_pkg::TEXEL_W-1:0] m_tdata,
	input  logic                        m_tlast,
	input  logic                        m_tuser,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [0:0]                  cfg_index,
	input  logic [cwh_pkg::DIM_W-1:0]   cfg_data,
	output int                          fail_count,
	output int                          pending
);

	localparam int MAXW = 4096;
	localparam int MAXH = 4096;

	typedef struct {
		logic [cwh_pkg::TEXEL_W-1:0] texel;
		logic                        row_end;
		logic                        image_end;
	} halved_t;

	halved_t                     halved_q[$];
	logic [cwh_pkg::TEXEL_W-1:0] even_row[MAXW];
	logic [cwh_pkg::TEXEL_W-1:0] even_col;
	int unsigned                 col_pos;
	int unsigned                 row_pos;
	logic [cwh_pkg::DIM_W-1:0]   width_reg;
	logic [cwh_pkg::DIM_W-1:0]   height_reg;

	function automatic int unsigned mean_half_up(int unsigned sum, int unsigned div);
		int unsigned v;
		v = (2 * sum + div) / (2 * div);
		return (v > 255) ? 255 : v;
	endfunction

	function automatic logic [cwh_pkg::TEXEL_W-1:0] blend_quad(
		logic [cwh_pkg::TEXEL_W-1:0] q[4]);
		int unsigned asum;
		int unsigned wsum;
		int unsigned psum;
		logic [cwh_pkg::TEXEL_W-1:0] res;
		asum = 0;
		res = '0;
		for (int i = 0; i < 4; i++)
			asum += q[i][31:24];
		for (int k = 0; k < 3; k++) begin
			wsum = 0;
			psum = 0;
			for (int i = 0; i < 4; i++) begin
				wsum += q[i][8*k +: 8] * q[i][31:24];
				psum += q[i][8*k +: 8];
			end
			res[8*k +: 8] = (asum > 0) ? 8'(mean_half_up(wsum, asum))
				: 8'(mean_half_up(psum, 4));
		end
		res[31:24] = 8'(mean_half_up(asum, 4));
		return res;
	endfunction

	task automatic take_texel(logic [cwh_pkg::TEXEL_W-1:0] t);
		int unsigned w;
		int unsigned h;
		int unsigned ow;
		int unsigned oh;
		int unsigned c;
		int unsigned r;
		int unsigned ox;
		int unsigned oy;
		logic [cwh_pkg::TEXEL_W-1:0] q[4];
		logic x_done;
		logic y_done;
		halved_t e;
		w = (width_reg < 1) ? 1 : (width_reg > MAXW) ? MAXW : width_reg;
		h = (height_reg < 1) ? 1 : (height_reg > MAXH) ? MAXH : height_reg;
		ow = (w / 2 > 1) ? w / 2 : 1;
		oh = (h / 2 > 1) ? h / 2 : 1;
		c = col_pos;
		r = row_pos;
		x_done = (w == 1) || c[0];
		y_done = (h == 1) || r[0];
		if (c >= w) c = 0;
		if (r >= h) r = 0;
		if (x_done && y_done) begin
			q[3] = t;
			q[2] = (w == 1) ? t : even_col;
			if (h == 1) begin
				q[1] = q[3];
				q[0] = q[2];
			end else begin
				q[1] = even_row[c];
				q[0] = (w == 1) ? q[1] : even_row[c - 1];
			end
			ox = (w == 1) ? 0 : c / 2;
			oy = (h == 1) ? 0 : r / 2;
			if (ox < ow && oy < oh) begin
				e.texel = blend_quad(q);
				e.row_end = (ox == ow - 1);
				e.image_end = (ox == ow - 1) && (oy == oh - 1);
				halved_q = {halved_q, e};
			end
		end
		if (w > 1 && !c[0]) even_col = t;
		if (h > 1 && !r[0]) even_row[c] = t;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	always @(posedge clk or negedge arst_n) begin
		halved_t e;
		if (!arst_n) begin
			halved_q.delete();
			for (int i = 0; i < MAXW; i++)
				even_row[i] = '0;
			even_col = '0;
			col_pos = 0;
			row_pos = 0;
			width_reg = cwh_pkg::DIM_W'(1);
			height_reg = cwh_pkg::DIM_W'(1);
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == cwh_pkg::CFG_WIDTH) width_reg = cfg_data;
				else height_reg = cfg_data;
				col_pos = 0;
				row_pos = 0;
			end
			if (s_tvalid && s_tready)
				take_texel(s_tdata);
			if (m_tvalid && m_tready) begin
				if (halved_q.size() == 0) begin
					$error("unexpected result: halved_texel %h", m_tdata);
					fail_count++;
				end else begin
					e = halved_q.pop_front();
					if (m_tdata !== e.texel) begin
						$error("halved_texel: expected %h, got %h", e.texel, m_tdata);
						fail_count++;
					end
					if (m_tuser !== e.row_end) begin
						$error("last_in_row: expected %b, got %b", e.row_end, m_tuser);
						fail_count++;
					end
					if (m_tlast !== e.image_end) begin
						$error("last_of_image: expected %b, got %b", e.image_end, m_tlast);
						fail_count++;
					end
				end
			end
		end
		pending = halved_q.size();
	end

endmodule

FILE: sim/tb_coverage_weighted_halving.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_coverage_weighted_halving
// Drives source levels of many sizes through the downsampler with random
// texels and random idle and stall patterns; the checker beside the block
// predicts and compares every halved texel.
// ----------------------------------------------------------------------------
module tb_coverage_weighted_halving;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE      = 80;

	logic                        clk;
	logic                        arst_n;
	logic                        s_tvalid;
	logic                        s_tready;
	logic [cwh_pkg::TEXEL_W-1:0] s_tdata;
	logic                        m_tvalid;
	logic                        m_tready;
	logic [cwh_pkg::TEXEL_W-1:0] m_tdata;
	logic                        m_tlast;
	logic                        m_tuser;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [0:0]                  cfg_index;
	logic [cwh_pkg::DIM_W-1:0]   cfg_data;
	int                          fail_count;
	int                          pending;
	int                          cycles;
	int unsigned                 send_pct;
	int unsigned                 stall_pct;
	int                          sent;
	bit                          paused;

	coverage_weighted_halving u_dut (.*);

	cwh_checker u_checker (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		m_tready <= ($urandom_range(99) >= stall_pct);
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [cwh_pkg::TEXEL_W-1:0] rand_texel();
		logic [cwh_pkg::TEXEL_W-1:0] t;
		t = $urandom;
		case ($urandom_range(3))
			0: t[31:24] = 8'h00;
			1: t[31:24] = 8'hff;
			2: t[31:24] = 8'($urandom_range(3));
			default: ;
		endcase
		return t;
	endfunction

	task automatic push_texel(logic [cwh_pkg::TEXEL_W-1:0] t);
		while ($urandom_range(99) < send_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= t;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [cwh_pkg::DIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic start_level(int unsigned w, int unsigned h, int unsigned mode);
		s_tvalid <= 1'b0;
		@(posedge clk);
		drain();
		write_reg(cwh_pkg::CFG_WIDTH, cwh_pkg::DIM_W'(w));
		write_reg(cwh_pkg::CFG_HEIGHT, cwh_pkg::DIM_W'(h));
		case (mode % 4)
			0: begin send_pct = 0; stall_pct = 0; end
			1: begin send_pct = 55; stall_pct = 0; end
			2: begin send_pct = 0; stall_pct = 55; end
			default: begin send_pct = 7; stall_pct = 7; end
		endcase
	endtask

	initial begin
		int unsigned w;
		int unsigned h;
		int unsigned n;
		int unsigned mode;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = cwh_pkg::CFG_WIDTH;
		cfg_data = '0;
		cycles = 0;
		send_pct = 0;
		stall_pct = 0;
		sent = 0;
		paused = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		start_level(1, 1, 0);
		push_texel('0);
		push_texel('1);
		push_texel(32'h00ff_ffff);
		push_texel(32'hff00_0000);
		start_level(2, 2, 1);
		repeat (4) push_texel({8'h00, 24'($urandom)});
		start_level(0, 0, 2);
		repeat (2) push_texel(rand_texel());
		start_level(3, 3, 3);
		repeat (9) push_texel(rand_texel());
		start_level(8191, 1, 0);
		repeat (6) push_texel(rand_texel());
		start_level(1, 8191, 2);
		repeat (4) push_texel(rand_texel());

		mode = 0;
		while (sent < 500) begin
			w = $urandom_range(1, 9);
			h = $urandom_range(1, 6);
			n = w * h * $urandom_range(1, 2);
			if ($urandom_range(7) == 0) n = $urandom_range(1, n);
			mode++;
			start_level(w, h, mode);
			for (int i = 0; i < n; i++) begin
				if (!paused && sent >= 300) begin
					paused = 1;
					s_tvalid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
				push_texel(rand_texel());
			end
		end
		s_tvalid <= 1'b0;
		stall_pct = 0;
		@(posedge clk);
		drain();

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
